// File: sv/clt_pkg.sv
// Shared types and constants of the cotangent Laplacian triplet block.
// Depends on nothing; used by the queue front end, the emitter and the top level.
package clt_pkg;

    // Number of sparse triplets emitted for each face.
    localparam int N_TRIPLETS = 9;
    localparam int TRIP_CNT_W = 4;
    localparam int WEIGHT_W   = 32;

    // Corner selectors for row and column indices.
    localparam logic [1:0] SEL_A = 2'd0;
    localparam logic [1:0] SEL_B = 2'd1;
    localparam logic [1:0] SEL_C = 2'd2;

    // Value codes: a diagonal sum of two corner weights or a negated weight.
    localparam logic [2:0] VAL_SUM_BC = 3'd0;
    localparam logic [2:0] VAL_SUM_AC = 3'd1;
    localparam logic [2:0] VAL_SUM_AB = 3'd2;
    localparam logic [2:0] VAL_NEG_A  = 3'd3;
    localparam logic [2:0] VAL_NEG_B  = 3'd4;
    localparam logic [2:0] VAL_NEG_C  = 3'd5;

    // Occupancy of the face queue.
    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

    function automatic logic [1:0] row_sel(input logic [TRIP_CNT_W-1:0] k);
        logic [1:0] r;
        case (k)
            4'd0, 4'd3, 4'd8: r = SEL_A;
            4'd1, 4'd4, 4'd5: r = SEL_B;
            default:          r = SEL_C;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] col_sel(input logic [TRIP_CNT_W-1:0] k);
        logic [1:0] c;
        case (k)
            4'd0, 4'd4, 4'd7: c = SEL_A;
            4'd1, 4'd3, 4'd6: c = SEL_B;
            default:          c = SEL_C;
        endcase
        return c;
    endfunction

    function automatic logic [2:0] val_code(input logic [TRIP_CNT_W-1:0] k);
        logic [2:0] v;
        case (k)
            4'd0:       v = VAL_SUM_BC;
            4'd1:       v = VAL_SUM_AC;
            4'd2:       v = VAL_SUM_AB;
            4'd3, 4'd4: v = VAL_NEG_C;
            4'd5, 4'd6: v = VAL_NEG_A;
            default:    v = VAL_NEG_B;
        endcase
        return v;
    endfunction

endpackage

// File: sv/clt_front.sv
// Front end: accepts faces, forms the edge vectors b-a, c-a and c-b and queues them.
// Depends on clt_pkg for the queue status type.
module clt_front #(
    parameter int IW = 20,
    parameter int CW = 24,
    localparam int ITW = ((3 * IW + 9 * CW + 7) / 8) * 8,
    localparam int D = CW + 1,
    localparam int EW = 3 * IW + 9 * D
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [ITW-1:0]    s_tdata,
    output logic              q_valid,
    input  logic              q_ready,
    output logic [EW-1:0]     q_data,
    output clt_pkg::qstat_t   qstat
);

    logic [EW-1:0] mem_reg [2];
    logic          wp_reg, rp_reg;
    logic [1:0]    cnt_reg;
    logic [EW-1:0] entry;
    logic          push, pop;

    // Edge vectors b-a, c-a and c-b, one bit wider than the coordinates.
    always_comb begin
        logic signed [D-1:0] p [3][3];
        logic [9*D-1:0] diffs;
        for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) begin
                p[i][k] = D'($signed(s_tdata[3*IW + (3*i+k)*CW +: CW]));
            end
        end
        for (int k = 0; k < 3; k++) begin
            diffs[k*D +: D]       = p[1][k] - p[0][k];
            diffs[(3+k)*D +: D]   = p[2][k] - p[0][k];
            diffs[(6+k)*D +: D]   = p[2][k] - p[1][k];
        end
        entry = {diffs, s_tdata[3*IW-1:0]};
    end

    assign s_tready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_data   = mem_reg[rp_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_valid && q_ready;
    assign qstat.full  = (cnt_reg == 2'd2);
    assign qstat.empty = (cnt_reg == 2'd0);

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wp_reg] <= entry;
        end
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) begin
                wp_reg <= ~wp_reg;
            end
            if (pop) begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

// File: sv/clt_math.sv
// Back end arithmetic: cross product, dots and squares on one shared multiplier,
// then a bit-serial square root and three bit-serial division lanes.
module clt_math #(
    parameter int IW = 20,
    parameter int CW = 24,
    localparam int D = CW + 1,
    localparam int EW = 3 * IW + 9 * D,
    localparam int QW = 2 * CW + 18
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    output logic              q_ready,
    input  logic [EW-1:0]     q_data,
    output logic              res_valid,
    input  logic              res_ready,
    output logic [3*IW-1:0]   res_idx,
    output logic [3*QW-1:0]   res_w,
    output logic              res_degen
);

    localparam int MW   = CW + 2;
    localparam int PW   = 2 * MW;
    localparam int CRW  = 2 * CW + 3;
    localparam int H    = CW + 1;
    localparam int RW   = 2 * CW + 3;
    localparam int SW   = 2 * RW;
    localparam int NW   = 2 * CW + 17;
    localparam int NMUL = 24;
    localparam int CNTW = $clog2(NW + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_SQRT = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]             state_reg;
    logic [CNTW-1:0]        cnt_reg;
    logic [EW-1:0]          ent_reg;
    logic signed [PW-1:0]   prod_reg;
    logic [4:0]             tag_reg;
    logic                   pv_reg;
    logic signed [CRW-1:0]  cr_reg [3];
    logic [2*H-1:0]         crmag_reg [3];
    logic signed [PW-1:0]   dot_reg [3];
    logic [SW-1:0]          s_reg;
    logic [RW+1:0]          rem_reg;
    logic [RW-1:0]          root_reg;
    logic [NW-1:0]          num_reg [3];
    logic [RW-1:0]          drem_reg [3];
    logic [2:0]             neg_reg;

    logic signed [D-1:0]    ab [3], ac [3], bc [3];
    logic signed [MW-1:0]   op_a, op_b;
    logic [4:0]             k5;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            ab[j] = $signed(ent_reg[3*IW + j*D +: D]);
            ac[j] = $signed(ent_reg[3*IW + (3+j)*D +: D]);
            bc[j] = $signed(ent_reg[3*IW + (6+j)*D +: D]);
        end
    end

    assign k5 = cnt_reg[4:0];

    // Operand schedule: six cross terms, nine dot terms, nine square partials.
    always_comb begin
        logic [MW-1:0] lo [3], hi [3];
        for (int i = 0; i < 3; i++) begin
            lo[i] = {1'b0, crmag_reg[i][H-1:0]};
            hi[i] = {1'b0, crmag_reg[i][2*H-1:H]};
        end
        op_a = '0;
        op_b = '0;
        case (k5)
            5'd0:  begin op_a = MW'(ab[1]); op_b = MW'(ac[2]); end
            5'd1:  begin op_a = MW'(ab[2]); op_b = MW'(ac[1]); end
            5'd2:  begin op_a = MW'(ab[2]); op_b = MW'(ac[0]); end
            5'd3:  begin op_a = MW'(ab[0]); op_b = MW'(ac[2]); end
            5'd4:  begin op_a = MW'(ab[0]); op_b = MW'(ac[1]); end
            5'd5:  begin op_a = MW'(ab[1]); op_b = MW'(ac[0]); end
            5'd6:  begin op_a = MW'(ab[0]); op_b = MW'(ac[0]); end
            5'd7:  begin op_a = MW'(ab[1]); op_b = MW'(ac[1]); end
            5'd8:  begin op_a = MW'(ab[2]); op_b = MW'(ac[2]); end
            5'd9:  begin op_a = MW'(ab[0]); op_b = MW'(bc[0]); end
            5'd10: begin op_a = MW'(ab[1]); op_b = MW'(bc[1]); end
            5'd11: begin op_a = MW'(ab[2]); op_b = MW'(bc[2]); end
            5'd12: begin op_a = MW'(ac[0]); op_b = MW'(bc[0]); end
            5'd13: begin op_a = MW'(ac[1]); op_b = MW'(bc[1]); end
            5'd14: begin op_a = MW'(ac[2]); op_b = MW'(bc[2]); end
            5'd15: begin op_a = $signed(lo[0]); op_b = $signed(lo[0]); end
            5'd16: begin op_a = $signed(hi[0]); op_b = $signed(lo[0]); end
            5'd17: begin op_a = $signed(hi[0]); op_b = $signed(hi[0]); end
            5'd18: begin op_a = $signed(lo[1]); op_b = $signed(lo[1]); end
            5'd19: begin op_a = $signed(hi[1]); op_b = $signed(lo[1]); end
            5'd20: begin op_a = $signed(hi[1]); op_b = $signed(hi[1]); end
            5'd21: begin op_a = $signed(lo[2]); op_b = $signed(lo[2]); end
            5'd22: begin op_a = $signed(hi[2]); op_b = $signed(lo[2]); end
            5'd23: begin op_a = $signed(hi[2]); op_b = $signed(hi[2]); end
            default: begin op_a = '0; op_b = '0; end
        endcase
    end

    // Square root step: two radicand bits enter the partial remainder.
    logic [RW+3:0] sq_rem, sq_trial;
    logic          sq_take;
    assign sq_rem   = {rem_reg, s_reg[SW-1:SW-2]};
    assign sq_trial = (RW+4)'({root_reg, 2'b01});
    assign sq_take  = (sq_rem >= sq_trial);

    assign q_ready   = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res_idx   = ent_reg[3*IW-1:0];
    assign res_degen = (root_reg == '0);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            logic signed [QW-1:0] q;
            q = $signed({1'b0, num_reg[i]});
            if (res_degen) begin
                res_w[i*QW +: QW] = '0;
            end else if (neg_reg[i]) begin
                res_w[i*QW +: QW] = -q;
            end else begin
                res_w[i*QW +: QW] = q;
            end
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
        tag_reg  <= k5;
        for (int i = 0; i < 3; i++) begin
            crmag_reg[i] <= cr_reg[i][CRW-1] ? (2*H)'(-cr_reg[i]) : (2*H)'(cr_reg[i]);
        end

        if (state_reg == ST_IDLE && q_valid) begin
            ent_reg  <= q_data;
            s_reg    <= '0;
            rem_reg  <= '0;
            root_reg <= '0;
            for (int i = 0; i < 3; i++) begin
                cr_reg[i]  <= '0;
                dot_reg[i] <= '0;
            end
        end

        // Accumulate the product issued in the previous cycle.
        if (pv_reg) begin
            case (tag_reg) inside
                5'd0, 5'd2, 5'd4: cr_reg[tag_reg[2:1]] <= prod_reg[CRW-1:0];
                5'd1, 5'd3, 5'd5:
                    cr_reg[tag_reg[2:1]] <= cr_reg[tag_reg[2:1]] - prod_reg[CRW-1:0];
                [5'd6:5'd8]:   dot_reg[0] <= dot_reg[0] + prod_reg;
                [5'd9:5'd11]:  dot_reg[1] <= dot_reg[1] + prod_reg;
                [5'd12:5'd14]: dot_reg[2] <= dot_reg[2] + prod_reg;
                5'd15, 5'd18, 5'd21: s_reg <= s_reg + SW'(unsigned'(prod_reg));
                5'd16, 5'd19, 5'd22:
                    s_reg <= s_reg + (SW'(unsigned'(prod_reg)) << (H + 1));
                5'd17, 5'd20, 5'd23:
                    s_reg <= s_reg + (SW'(unsigned'(prod_reg)) << (2 * H));
                default: ;
            endcase
        end

        if (state_reg == ST_SQRT) begin
            s_reg <= s_reg << 2;
            if (sq_take) begin
                rem_reg  <= (RW+2)'(sq_rem - sq_trial);
                root_reg <= {root_reg[RW-2:0], 1'b1};
            end else begin
                rem_reg  <= sq_rem[RW+1:0];
                root_reg <= {root_reg[RW-2:0], 1'b0};
            end
            // Load the division lanes with |dot| * 2^15; corner B uses -dot.
            if (cnt_reg == CNTW'(RW - 1)) begin
                for (int i = 0; i < 3; i++) begin
                    logic signed [PW-1:0] dv;
                    logic [PW-1:0] mg;
                    dv = (i == 1) ? -dot_reg[i] : dot_reg[i];
                    mg = dv[PW-1] ? unsigned'(-dv) : unsigned'(dv);
                    num_reg[i]  <= {mg[2*CW+1:0], 15'd0};
                    drem_reg[i] <= '0;
                    neg_reg[i]  <= dv[PW-1];
                end
            end
        end

        if (state_reg == ST_DIV) begin
            for (int i = 0; i < 3; i++) begin
                logic [RW:0] r2;
                r2 = {drem_reg[i], num_reg[i][NW-1]};
                if (r2 >= {1'b0, root_reg}) begin
                    drem_reg[i] <= RW'(r2 - {1'b0, root_reg});
                    num_reg[i]  <= {num_reg[i][NW-2:0], 1'b1};
                end else begin
                    drem_reg[i] <= r2[RW-1:0];
                    num_reg[i]  <= {num_reg[i][NW-2:0], 1'b0};
                end
            end
        end

        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            pv_reg    <= 1'b0;
        end else begin
            pv_reg <= (state_reg == ST_MUL) && (cnt_reg < CNTW'(NMUL));
            case (state_reg)
                ST_IDLE: begin
                    cnt_reg <= '0;
                    if (q_valid) begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    if (cnt_reg == CNTW'(NMUL)) begin
                        cnt_reg   <= '0;
                        state_reg <= ST_SQRT;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_SQRT: begin
                    if (cnt_reg == CNTW'(RW - 1)) begin
                        cnt_reg   <= '0;
                        state_reg <= ST_DIV;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_DIV: begin
                    if (cnt_reg == CNTW'(NW - 1)) begin
                        cnt_reg   <= '0;
                        state_reg <= ST_DONE;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_DONE: begin
                    if (res_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// File: sv/clt_emit.sv
// Triplet emitter: holds one face's weights and sends its nine saturated triplets.
// Depends on clt_pkg for the triplet order and value codes.
module clt_emit #(
    parameter int IW = 20,
    parameter int CW = 24,
    localparam int QW = 2 * CW + 18,
    localparam int OTW = ((2 * IW + clt_pkg::WEIGHT_W + 7) / 8) * 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              res_valid,
    output logic              res_ready,
    input  logic [3*IW-1:0]   res_idx,
    input  logic [3*QW-1:0]   res_w,
    input  logic              res_degen,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OTW-1:0]    m_tdata,
    output logic              m_tlast,
    output logic              m_tuser
);

    localparam int WW = clt_pkg::WEIGHT_W;

    logic                            h_valid_reg;
    logic [3*IW-1:0]                 h_idx_reg;
    logic [3*QW-1:0]                 h_w_reg;
    logic                            h_degen_reg;
    logic [clt_pkg::TRIP_CNT_W-1:0]  cnt_reg;
    logic                            load;
    logic [IW-1:0]                   row, col;
    logic [WW-1:0]                   wsat;

    assign res_ready = !h_valid_reg;
    assign load      = h_valid_reg && (!m_tvalid || m_tready);

    always_comb begin
        logic signed [QW:0] wa, wb, wc, v;
        logic [QW-WW+1:0] top;
        wa = $signed({h_w_reg[QW-1], h_w_reg[QW-1:0]});
        wb = $signed({h_w_reg[2*QW-1], h_w_reg[2*QW-1:QW]});
        wc = $signed({h_w_reg[3*QW-1], h_w_reg[3*QW-1:2*QW]});
        case (clt_pkg::val_code(cnt_reg))
            clt_pkg::VAL_SUM_BC: v = wb + wc;
            clt_pkg::VAL_SUM_AC: v = wa + wc;
            clt_pkg::VAL_SUM_AB: v = wa + wb;
            clt_pkg::VAL_NEG_A:  v = -wa;
            clt_pkg::VAL_NEG_B:  v = -wb;
            default:             v = -wc;
        endcase
        top = v[QW:WW-1];
        if (top == '0 || top == '1) begin
            wsat = v[WW-1:0];
        end else if (v[QW]) begin
            wsat = {1'b1, {(WW-1){1'b0}}};
        end else begin
            wsat = {1'b0, {(WW-1){1'b1}}};
        end
        row = h_idx_reg[clt_pkg::row_sel(cnt_reg)*IW +: IW];
        col = h_idx_reg[clt_pkg::col_sel(cnt_reg)*IW +: IW];
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            h_idx_reg   <= res_idx;
            h_w_reg     <= res_w;
            h_degen_reg <= res_degen;
        end
        if (load) begin
            m_tdata <= OTW'({wsat, col, row});
            m_tlast <= (cnt_reg == clt_pkg::TRIP_CNT_W'(clt_pkg::N_TRIPLETS - 1));
            m_tuser <= h_degen_reg;
        end
        if (!aresetn) begin
            h_valid_reg <= 1'b0;
            cnt_reg     <= '0;
            m_tvalid    <= 1'b0;
        end else begin
            if (load) begin
                m_tvalid <= 1'b1;
                if (cnt_reg == clt_pkg::TRIP_CNT_W'(clt_pkg::N_TRIPLETS - 1)) begin
                    cnt_reg     <= '0;
                    h_valid_reg <= 1'b0;
                end else begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end else if (m_tready) begin
                m_tvalid <= 1'b0;
            end
            if (res_valid && res_ready) begin
                h_valid_reg <= 1'b1;
            end
        end
    end

endmodule

// File: sv/cotangent_laplace_triplets.sv
// Cotangent Laplacian triplets: nine sparse triplets per triangle face.
// Faces go one at a time through the bit-serial square root and the three bit-serial
// division lanes; the face queue and the emitter let the next face overlap them.
// Reset is synchronous and active low; it empties the queue and all control state.
module cotangent_laplace_triplets #(
    parameter int INDEX_WIDTH = 20,
    parameter int COORD_WIDTH = 24,
    localparam int ITW = ((3 * INDEX_WIDTH + 9 * COORD_WIDTH + 7) / 8) * 8,
    localparam int OTW = ((2 * INDEX_WIDTH + clt_pkg::WEIGHT_W + 7) / 8) * 8
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    // Fields from bit 0 up: index_a, index_b, index_c, ax, ay, az, bx, by_coord,
    // bz, cx, cy, cz, then zero fill.
    input  logic [ITW-1:0]  s_tdata,
    output logic            m_tvalid,
    input  logic            m_tready,
    // Fields from bit 0 up: row_index, col_index, weight, then zero fill.
    output logic [OTW-1:0]  m_tdata,
    // The tlast flag is last_of_face, set on the ninth triplet of each face.
    output logic            m_tlast,
    // The only user field: degenerate, set on all triplets of a zero-area face.
    output logic            m_tuser
);

    localparam int D  = COORD_WIDTH + 1;
    localparam int EW = 3 * INDEX_WIDTH + 9 * D;
    localparam int QW = 2 * COORD_WIDTH + 18;
    localparam int WLO = 2 * INDEX_WIDTH;

    // The front end forms edge vectors and parks up to two faces in its queue,
    // so the input keeps flowing while the back end is busy on an earlier face.
    logic                      q_valid, q_ready;
    logic [EW-1:0]             q_data;
    clt_pkg::qstat_t           qstat;

    // Finished corner weights handed from the arithmetic to the emitter.
    logic                      res_valid, res_ready, res_degen;
    logic [3*INDEX_WIDTH-1:0]  res_idx;
    logic [3*QW-1:0]           res_w;

    clt_front #(.IW(INDEX_WIDTH), .CW(COORD_WIDTH)) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_data   (q_data),
        .qstat    (qstat)
    );

    // The arithmetic works one face at a time: a shared multiplier for the cross
    // product, the corner dots and the squared cross terms, then the root and the
    // three divisions by the root.
    clt_math #(.IW(INDEX_WIDTH), .CW(COORD_WIDTH)) u_math (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_data    (q_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_idx   (res_idx),
        .res_w     (res_w),
        .res_degen (res_degen)
    );

    // The emitter streams the nine triplets while the next face is computed.
    clt_emit #(.IW(INDEX_WIDTH), .CW(COORD_WIDTH)) u_emit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_idx   (res_idx),
        .res_w     (res_w),
        .res_degen (res_degen),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    // A full queue can never also read as empty.
    a_queue_status: assert property (@(posedge aclk) disable iff (!aresetn)
        qstat.full |-> !qstat.empty)
        else $error("queue reports full and empty together");

    // The back end only takes a face when the queue holds one.
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_valid && q_ready) |-> !qstat.empty)
        else $error("face taken from an empty queue");

    // A zero-area face carries zero weights on every triplet.
    a_degen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[WLO +: clt_pkg::WEIGHT_W] == '0))
        else $error("degenerate face with nonzero weight");

endmodule

// File: verif/tb.sv
// Self-checking bench for cotangent_laplace_triplets: random and directed faces in,
// nine sparse triplets out per face, checked against a bit-exact predictor.
// Depends on clt_pkg and the cotangent_laplace_triplets RTL only.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IW    = 20;
    localparam int CW    = 24;
    localparam int ITW   = ((3 * IW + 9 * CW + 7) / 8) * 8;
    localparam int OTW   = ((2 * IW + clt_pkg::WEIGHT_W + 7) / 8) * 8;
    localparam int LIMIT = 1000000;
    localparam int DRAIN = 4 * CW + 100;

    typedef logic signed [127:0] wide_t;

    // One expected triplet.
    typedef struct {
        logic [IW-1:0]                row;
        logic [IW-1:0]                col;
        logic [clt_pkg::WEIGHT_W-1:0] weight;
        logic                         last;
        logic                         degen;
    } triplet_t;

    // Holds the expected triplets of every accepted face and checks results in order.
    class triplet_board;
        triplet_t pending[$];
        int       errors = 0;

        // Floor square root of a nonnegative value below 2^110.
        function automatic wide_t isqrt(wide_t s);
            logic [127:0] r, c;
            r = '0;
            for (int i = 55; i >= 0; i--) begin
                c = r | (128'd1 << i);
                if (c * c <= s) r = c;
            end
            return r;
        endfunction

        function automatic logic [clt_pkg::WEIGHT_W-1:0] clip32(wide_t v);
            if (v > wide_t'(64'sh7FFF_FFFF)) return 32'h7FFF_FFFF;
            if (v < -wide_t'(64'sh8000_0000)) return 32'h8000_0000;
            return v[31:0];
        endfunction

        function automatic wide_t dot(wide_t u[3], wide_t v[3]);
            return u[0] * v[0] + u[1] * v[1] + u[2] * v[2];
        endfunction

        // Notes an accepted face and queues its nine triplets.
        function void note_face(logic [ITW-1:0] d);
            logic [IW-1:0] ix[3];
            wide_t p[3][3], ab[3], ac[3], ba[3], bc[3], ca[3], cb[3], cr[3];
            wide_t len, wa, wb, wc, val[9];
            logic [1:0] rsel[9], csel[9];
            logic degen;
            triplet_t t;
            for (int i = 0; i < 3; i++) ix[i] = d[i*IW +: IW];
            for (int i = 0; i < 3; i++)
                for (int k = 0; k < 3; k++)
                    p[i][k] = wide_t'($signed(d[3*IW + (i*3+k)*CW +: CW]));
            for (int k = 0; k < 3; k++) begin
                ab[k] = p[1][k] - p[0][k];
                ac[k] = p[2][k] - p[0][k];
                bc[k] = p[2][k] - p[1][k];
                ba[k] = -ab[k];
                ca[k] = -ac[k];
                cb[k] = -bc[k];
            end
            cr[0] = ab[1] * ac[2] - ab[2] * ac[1];
            cr[1] = ab[2] * ac[0] - ab[0] * ac[2];
            cr[2] = ab[0] * ac[1] - ab[1] * ac[0];
            len   = isqrt(dot(cr, cr));
            degen = (len == 0);
            if (degen) begin
                wa = 0; wb = 0; wc = 0;
            end else begin
                // Signed division truncates toward zero, as the block does.
                wa = (dot(ab, ac) <<< 15) / len;
                wb = (dot(ba, bc) <<< 15) / len;
                wc = (dot(ca, cb) <<< 15) / len;
            end
            val = '{wb + wc, wa + wc, wa + wb, -wc, -wc, -wa, -wa, -wb, -wb};
            rsel = '{clt_pkg::SEL_A, clt_pkg::SEL_B, clt_pkg::SEL_C,
                     clt_pkg::SEL_A, clt_pkg::SEL_B, clt_pkg::SEL_B,
                     clt_pkg::SEL_C, clt_pkg::SEL_C, clt_pkg::SEL_A};
            csel = '{clt_pkg::SEL_A, clt_pkg::SEL_B, clt_pkg::SEL_C,
                     clt_pkg::SEL_B, clt_pkg::SEL_A, clt_pkg::SEL_C,
                     clt_pkg::SEL_B, clt_pkg::SEL_A, clt_pkg::SEL_C};
            for (int n = 0; n < clt_pkg::N_TRIPLETS; n++) begin
                t.row    = ix[rsel[n]];
                t.col    = ix[csel[n]];
                t.weight = clip32(val[n]);
                t.last   = (n == clt_pkg::N_TRIPLETS - 1);
                t.degen  = degen;
                pending.push_back(t);
            end
        endfunction

        // Compares one accepted triplet with the oldest expectation.
        function void check_triplet(logic [OTW-1:0] d, logic last, logic degen);
            triplet_t e;
            if (pending.size() == 0) begin
                $error("triplet with no face pending: tdata=%h", d);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (d[IW-1:0] !== e.row) begin
                $error("row_index: expected %0d, got %0d", e.row, d[IW-1:0]);
                errors++;
            end
            if (d[IW +: IW] !== e.col) begin
                $error("col_index: expected %0d, got %0d", e.col, d[IW +: IW]);
                errors++;
            end
            if (d[2*IW +: clt_pkg::WEIGHT_W] !== e.weight) begin
                $error("weight: expected %h, got %h", e.weight,
                       d[2*IW +: clt_pkg::WEIGHT_W]);
                errors++;
            end
            if (last !== e.last) begin
                $error("last_of_face: expected %b, got %b", e.last, last);
                errors++;
            end
            if (degen !== e.degen) begin
                $error("degenerate: expected %b, got %b", e.degen, degen);
                errors++;
            end
        endfunction
    endclass

    logic           aclk = 1'b0;
    logic           aresetn = 1'b0;
    logic           s_tvalid = 1'b0;
    logic           s_tready;
    logic [ITW-1:0] s_tdata = '0;
    logic           m_tvalid;
    logic           m_tready = 1'b0;
    logic [OTW-1:0] m_tdata;
    logic           m_tlast;
    logic           m_tuser;

    triplet_board board = new();

    // Idle percentages of both sides, changed per phase by the main sequence.
    int send_idle = 0;
    int recv_idle = 0;
    // Cycles left in a forced receiver hold-off.
    int holdoff_left = 0;
    int cycles = 0;

    cotangent_laplace_triplets uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Both channels are sampled at the rising edge; the predictor sees exactly
    // the faces that the block accepted.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) board.note_face(s_tdata);
        if (aresetn && m_tvalid && m_tready) board.check_triplet(m_tdata, m_tlast, m_tuser);
    end

    // The receiver changes tready at the falling edge. A hold-off counts down
    // in this process alone while the sender keeps offering faces.
    always @(negedge aclk) begin
        if (holdoff_left > 0) begin
            holdoff_left--;
            m_tready = 1'b0;
        end else begin
            m_tready = ($urandom_range(99) >= recv_idle);
        end
    end

    // Watchdog for a block that hangs.
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic logic [ITW-1:0] pack_face(logic [IW-1:0] ix[3],
                                                logic signed [CW-1:0] p[9]);
        logic [ITW-1:0] d;
        d = '0;
        for (int i = 0; i < 3; i++) d[i*IW +: IW] = ix[i];
        for (int i = 0; i < 9; i++) d[3*IW + i*CW +: CW] = p[i];
        return d;
    endfunction

    // Offers one face, starting and ending at a falling edge.
    task automatic send_face(logic [ITW-1:0] d);
        while ($urandom_range(99) < send_idle) @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata  = d;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    task automatic send_coords(logic [IW-1:0] a, logic [IW-1:0] b, logic [IW-1:0] c,
                               logic signed [CW-1:0] p[9]);
        logic [IW-1:0] ix[3];
        ix = '{a, b, c};
        send_face(pack_face(ix, p));
    endtask

    // Random face: mostly full-range or small triangles, some collinear,
    // some with a repeated corner, some with shared indices.
    task automatic send_random_face();
        logic [IW-1:0] ix[3];
        logic signed [CW-1:0] p[9];
        int kind, span;
        kind = $urandom_range(9);
        span = (kind < 5) ? 0 : (1 << $urandom_range(4, 14));
        for (int i = 0; i < 3; i++) ix[i] = IW'($urandom);
        if ($urandom_range(9) == 0) ix[$urandom_range(2)] = ix[$urandom_range(2)];
        for (int i = 0; i < 9; i++)
            p[i] = (span == 0) ? CW'($urandom) : CW'($urandom_range(2 * span) - span);
        if (kind == 8) begin
            // C = 2B - A keeps the corners on one line.
            for (int k = 0; k < 3; k++) p[6+k] = 2 * p[3+k] - p[k];
        end else if (kind == 9) begin
            for (int k = 0; k < 3; k++) p[3+k] = p[k];
        end
        send_face(pack_face(ix, p));
    endtask

    localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic signed [CW-1:0] ONE  = 24'sd65536;
    localparam logic [IW-1:0]        IMAX = '1;

    initial begin
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Phase one: the sender idles lightly and the receiver heavily.
        send_idle = 32;
        recv_idle = 82;

        // Directed faces. A unit right triangle in the xy plane.
        send_coords(0, 1, 2, '{0, 0, 0, ONE, 0, 0, 0, ONE, 0});
        // Index extremes on an equilateral-like face.
        send_coords(IMAX, 0, IMAX, '{0, 0, 0, ONE, 0, 0, ONE / 2, 56756, 0});
        // Every corner at the origin: a zero-area face.
        send_coords(5, 6, 7, '{0, 0, 0, 0, 0, 0, 0, 0, 0});
        // Three distinct collinear corners: also zero area.
        send_coords(8, 9, 10, '{0, 0, 0, ONE, ONE, ONE, 2 * ONE, 2 * ONE, 2 * ONE});
        // Two coincident corners.
        send_coords(11, 12, 13, '{ONE, 0, 0, ONE, 0, 0, 0, ONE, ONE});
        // Coordinates at both extremes of the range.
        send_coords(14, 15, 16, '{CMIN, CMIN, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMAX});
        send_coords(17, 18, 19, '{CMAX, CMAX, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMIN});
        // A very thin sliver whose weights leave the 32-bit range and saturate.
        send_coords(20, 21, 22, '{CMIN, 0, 0, CMAX, 0, 0, CMAX, 1, 0});
        send_coords(23, 24, 25, '{CMAX, 0, 0, CMIN, 0, 0, CMIN, 0, -1});
        // An obtuse corner gives a negative weight.
        send_coords(26, 27, 28, '{0, 0, 0, 4 * ONE, 0, 0, 2 * ONE, ONE / 8, 0});
        // The smallest nonzero area.
        send_coords(29, 30, 31, '{0, 0, 0, 1, 0, 0, 0, 0, 1});
        // Repeated vertex indices are passed through unchecked.
        send_coords(7, 7, 7, '{ONE, 2 * ONE, 0, 0, ONE, ONE, 3 * ONE, 0, -ONE});
        send_coords(0, 0, IMAX, '{-ONE, 0, ONE, ONE, -ONE, 0, 0, ONE, -ONE});

        // Hold the receiver off long enough for the block to fill and stall its input.
        holdoff_left = 3000;
        repeat (100) send_random_face();

        // Pause until every triplet has come out before the next phase.
        while (board.pending.size() != 0) @(negedge aclk);

        // Phase two: the sender idles heavily and the receiver lightly.
        send_idle = 82;
        recv_idle = 32;
        repeat (120) send_random_face();

        // Phase three: neither side idles.
        send_idle = 0;
        recv_idle = 0;
        repeat (120) send_random_face();

        while (board.pending.size() != 0) @(negedge aclk);
        repeat (DRAIN) @(negedge aclk);

        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
